>>> rtl/pcob_pkg.sv
// Package: shared types, widths, codes and helpers for the oriented box block.
`timescale 1ns / 1ps
package pcob_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 3 * COORD_W + 4;
  localparam int DVS_W   = 2 * COORD_W + 4;
  localparam int CNT_W   = $clog2(PROD_W + 2);

  localparam logic [CNT_W-1:0] CNT_MAC_END = CNT_W'(DIFF_W);
  localparam logic [CNT_W-1:0] CNT_DIV_END = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0] CNT_DIV_FIN = CNT_W'(PROD_W + 1);

  localparam logic [2:0] KIND_CENTER    = 3'd0;
  localparam logic [2:0] KIND_WEST_NEAR = 3'd1;
  localparam logic [2:0] KIND_WEST_FAR  = 3'd2;
  localparam logic [2:0] KIND_EAST_FAR  = 3'd3;
  localparam logic [2:0] KIND_EAST_NEAR = 3'd4;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PROD_W:0]    sum_t;
  typedef logic signed [DVS_W-1:0]   dvs_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic [2:0]                item_kind;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_z_bottom;
    logic                      degenerate;
    logic                      last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CR1, ST_CR2, ST_CENTER, ST_N1, ST_N2,
    ST_MX, ST_DX, ST_MY, ST_DY, ST_CORNER
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD_MAC, OP_MAC_STEP, OP_LOAD_DIV, OP_DIV_STEP, OP_DIV_DONE, OP_SAVE_CR
  } dp_op_t;

  typedef enum logic [2:0] {
    SEL_CR1, SEL_CR2, SEL_N1, SEL_N2, SEL_X, SEL_Y
  } mac_sel_t;

  typedef struct packed {
    logic       accept;
    dp_op_t     op;
    mac_sel_t   sel;
    logic       clr;
    logic       last_bit;
    logic       axis_y;
    logic       emit;
    logic       emit_center;
    logic [1:0] corner;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic deg;
  } dp_status_t;

  function automatic diff_t sub_ext(coord_t a, coord_t b);
    return diff_t'({a[COORD_W-1], a}) - diff_t'({b[COORD_W-1], b});
  endfunction

  function automatic coord_t half_floor(coord_t a, coord_t b);
    diff_t s;
    s = diff_t'({a[COORD_W-1], a}) + diff_t'({b[COORD_W-1], b});
    return s[DIFF_W-1:1];
  endfunction

  function automatic coord_t sat_coord(sum_t v);
    sum_t hi;
    sum_t lo;
    hi = {{(PROD_W + 2 - COORD_W){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = {{(PROD_W + 2 - COORD_W){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > hi) return hi[COORD_W-1:0];
    else if (v < lo) return lo[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

  function automatic logic [2:0] corner_kind(logic [1:0] c);
    logic [2:0] k;
    unique case (c)
      2'd0: k = KIND_WEST_NEAR;
      2'd1: k = KIND_WEST_FAR;
      2'd2: k = KIND_EAST_FAR;
      default: k = KIND_EAST_NEAR;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/pcob_ctrl.sv
// Controller: sequences multiply, divide and emit steps after the last point.
`timescale 1ns / 1ps
module pcob_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_point,
  input  pcob_pkg::dp_status_t status,
  output logic                busy,
  output pcob_pkg::dp_cmd_t   cmd
);
  import pcob_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      corner_r <= corner_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    corner_nxt      = corner_r;
    cmd.accept      = 1'b0;
    cmd.op          = OP_NONE;
    cmd.sel         = SEL_CR1;
    cmd.clr         = 1'b0;
    cmd.last_bit    = 1'b0;
    cmd.axis_y      = 1'b0;
    cmd.emit        = 1'b0;
    cmd.emit_center = 1'b0;
    cmd.corner      = corner_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && last_point) begin
          state_nxt = ST_CR1;
          cnt_nxt   = '0;
        end
      end
      ST_CR1, ST_CR2, ST_N1, ST_N2, ST_MX, ST_MY: begin
        unique case (state_r)
          ST_CR1:  cmd.sel = SEL_CR1;
          ST_CR2:  cmd.sel = SEL_CR2;
          ST_N1:   cmd.sel = SEL_N1;
          ST_N2:   cmd.sel = SEL_N2;
          ST_MX:   cmd.sel = SEL_X;
          default: cmd.sel = SEL_Y;
        endcase
        cmd.clr      = (state_r == ST_CR1) || (state_r == ST_N1) ||
                       (state_r == ST_MX) || (state_r == ST_MY);
        cmd.op       = (cnt_r == '0) ? OP_LOAD_MAC : OP_MAC_STEP;
        cmd.last_bit = (cnt_r == CNT_MAC_END);
        if (cnt_r == CNT_MAC_END) begin
          cnt_nxt = '0;
          unique case (state_r)
            ST_CR1:  state_nxt = ST_CR2;
            ST_CR2:  state_nxt = ST_CENTER;
            ST_N1:   state_nxt = ST_N2;
            ST_N2:   state_nxt = ST_MX;
            ST_MX:   state_nxt = ST_DX;
            default: state_nxt = ST_DY;
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DX, ST_DY: begin
        cmd.axis_y = (state_r == ST_DY);
        if (cnt_r == '0) cmd.op = OP_LOAD_DIV;
        else if (cnt_r == CNT_DIV_FIN) cmd.op = OP_DIV_DONE;
        else cmd.op = OP_DIV_STEP;
        if (cnt_r == CNT_DIV_FIN) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_DX) ? ST_MY : ST_CORNER;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CENTER: begin
        cmd.op          = OP_SAVE_CR;
        cmd.emit        = 1'b1;
        cmd.emit_center = 1'b1;
        state_nxt       = status.acc_zero ? ST_CORNER : ST_N1;
      end
      ST_CORNER: begin
        cmd.emit = 1'b1;
        if (corner_r == CORNER_LAST) begin
          corner_nxt = '0;
          state_nxt  = ST_IDLE;
        end else begin
          corner_nxt = corner_r + 1'b1;
          state_nxt  = status.deg ? ST_CORNER : ST_N1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/pcob_dp.sv
// Datapath: extreme tracking, shift-add multiplier, restoring divider, result register.
`timescale 1ns / 1ps
module pcob_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcob_pkg::point_t     in_item,
  input  pcob_pkg::dp_cmd_t    cmd,
  output pcob_pkg::dp_status_t status,
  output logic                 out_strobe,
  output pcob_pkg::result_t    out_item
);
  import pcob_pkg::*;

  coord_t min_x_r, max_x_r, min_y_r, max_y_r, min_z_r, max_z_r;
  coord_t west_y_r, east_y_r, far_x_r, near_x_r;
  logic   have_point_r;

  prod_t            acc_r, mcand_r;
  diff_t            mplier_r;
  dvs_t             num_r, cr_r;
  logic             deg_r;
  logic [PROD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic             qneg_r;
  coord_t           ox_r, oy_r;
  logic             out_strobe_r;
  result_t          out_item_r;

  diff_t  d1x, d1y, d2x, d2y, dqx, dqy, mac_b;
  prod_t  mac_a, addend;
  coord_t px, py, qx, qy, cx, cy, cz;
  logic   qfar, acc_zero;
  logic [DVS_W-1:0] rem_sh;
  sum_t   qsig, psum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_point_r <= 1'b0;
    end else if (cmd.accept) begin
      have_point_r <= !in_item.last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (!have_point_r) begin
        min_x_r  <= in_item.point_x;
        max_x_r  <= in_item.point_x;
        min_y_r  <= in_item.point_y;
        max_y_r  <= in_item.point_y;
        min_z_r  <= in_item.point_z;
        max_z_r  <= in_item.point_z;
        west_y_r <= in_item.point_y;
        east_y_r <= in_item.point_y;
        far_x_r  <= in_item.point_x;
        near_x_r <= in_item.point_x;
      end else begin
        if (in_item.point_z > max_z_r) max_z_r <= in_item.point_z;
        if (in_item.point_z < min_z_r) min_z_r <= in_item.point_z;
        if (in_item.point_x > max_x_r) begin
          max_x_r  <= in_item.point_x;
          east_y_r <= in_item.point_y;
        end
        if (in_item.point_x < min_x_r) begin
          min_x_r  <= in_item.point_x;
          west_y_r <= in_item.point_y;
        end
        if (in_item.point_y > max_y_r) begin
          max_y_r <= in_item.point_y;
          far_x_r <= in_item.point_x;
        end
        if (in_item.point_y < min_y_r) begin
          min_y_r  <= in_item.point_y;
          near_x_r <= in_item.point_x;
        end
      end
    end
  end

  assign d1x  = sub_ext(far_x_r, near_x_r);
  assign d1y  = sub_ext(max_y_r, min_y_r);
  assign d2x  = sub_ext(max_x_r, min_x_r);
  assign d2y  = sub_ext(east_y_r, west_y_r);
  assign px   = cmd.corner[1] ? max_x_r : min_x_r;
  assign py   = cmd.corner[1] ? east_y_r : west_y_r;
  assign qfar = cmd.corner[1] ^ cmd.corner[0];
  assign qx   = qfar ? far_x_r : near_x_r;
  assign qy   = qfar ? max_y_r : min_y_r;
  assign dqx  = sub_ext(qx, px);
  assign dqy  = sub_ext(qy, py);
  assign cx   = half_floor(min_x_r, max_x_r);
  assign cy   = half_floor(min_y_r, max_y_r);
  assign cz   = half_floor(min_z_r, max_z_r);
  assign acc_zero = (acc_r == '0);

  always_comb begin
    unique case (cmd.sel)
      SEL_CR1: begin
        mac_a = {{(PROD_W-DIFF_W){d1x[DIFF_W-1]}}, d1x};
        mac_b = d2y;
      end
      SEL_CR2: begin
        mac_a = -{{(PROD_W-DIFF_W){d1y[DIFF_W-1]}}, d1y};
        mac_b = d2x;
      end
      SEL_N1: begin
        mac_a = {{(PROD_W-DIFF_W){dqx[DIFF_W-1]}}, dqx};
        mac_b = d2y;
      end
      SEL_N2: begin
        mac_a = -{{(PROD_W-DIFF_W){dqy[DIFF_W-1]}}, dqy};
        mac_b = d2x;
      end
      SEL_X: begin
        mac_a = acc_r;
        mac_b = d1x;
      end
      default: begin
        mac_a = {{(PROD_W-DVS_W){num_r[DVS_W-1]}}, num_r};
        mac_b = d1y;
      end
    endcase
  end

  assign addend = cmd.last_bit ? -mcand_r : mcand_r;
  assign rem_sh = {rem_r[DVS_W-2:0], quo_r[PROD_W-1]};
  assign qsig   = qneg_r ? -({1'b0, quo_r} + sum_t'(rem_r != '0)) : sum_t'({1'b0, quo_r});
  assign psum   = qsig + {{(PROD_W+1-COORD_W){(cmd.axis_y ? py[COORD_W-1] : px[COORD_W-1])}},
                          (cmd.axis_y ? py : px)};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD_MAC: begin
        mcand_r  <= mac_a;
        mplier_r <= mac_b;
        if (cmd.clr) acc_r <= '0;
        if (cmd.sel == SEL_X) num_r <= acc_r[DVS_W-1:0];
      end
      OP_MAC_STEP: begin
        if (mplier_r[0]) acc_r <= acc_r + addend;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >>> 1;
      end
      OP_LOAD_DIV: begin
        quo_r  <= acc_r[PROD_W-1] ? -acc_r : acc_r;
        dvs_r  <= cr_r[DVS_W-1] ? -cr_r : cr_r;
        rem_r  <= '0;
        qneg_r <= acc_r[PROD_W-1] ^ cr_r[DVS_W-1];
      end
      OP_DIV_STEP: begin
        if (rem_sh >= dvs_r) begin
          rem_r <= rem_sh - dvs_r;
          quo_r <= {quo_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[PROD_W-2:0], 1'b0};
        end
      end
      OP_DIV_DONE: begin
        if (cmd.axis_y) oy_r <= sat_coord(psum);
        else ox_r <= sat_coord(psum);
      end
      OP_SAVE_CR: begin
        cr_r  <= acc_r[DVS_W-1:0];
        deg_r <= acc_zero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else out_strobe_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.out_z_bottom <= min_z_r;
      if (cmd.emit_center) begin
        out_item_r.item_kind   <= KIND_CENTER;
        out_item_r.out_x       <= cx;
        out_item_r.out_y       <= cy;
        out_item_r.out_z       <= cz;
        out_item_r.degenerate  <= acc_zero;
        out_item_r.last_result <= 1'b0;
      end else begin
        out_item_r.item_kind   <= corner_kind(cmd.corner);
        out_item_r.out_x       <= deg_r ? cx : ox_r;
        out_item_r.out_y       <= deg_r ? cy : oy_r;
        out_item_r.out_z       <= max_z_r;
        out_item_r.degenerate  <= deg_r;
        out_item_r.last_result <= (cmd.corner == CORNER_LAST);
      end
    end
  end

  assign status.acc_zero = acc_zero;
  assign status.deg      = deg_r;
  assign out_strobe      = out_strobe_r;
  assign out_item        = out_item_r;

endmodule

>>> rtl/point_cluster_oriented_box_top.sv
// Top level: oriented bounding box of one lidar point cluster.
//
//  channel  ports                  handshake
//  input    in_item               start & !busy accepts a request
//  result   out_item, out_strobe  each result shown for a single cycle, no back-pressure
//
// A point that is not the last of its cluster only updates the extremes; busy stays low.
// The last point starts the box solve: the cross product, then the center, then per
// corner the multiply steps and the divide steps plus one emit, all on the one shared
// shift-add multiplier and the one restoring divider.
// A degenerate box skips the corner solve: five results in consecutive cycles.
// Reset is synchronous, active low; the receiver cannot stall.
`timescale 1ns / 1ps
module point_cluster_oriented_box_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pcob_pkg::point_t  in_item,
  output logic              out_strobe,
  output pcob_pkg::result_t out_item
);
  import pcob_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pcob_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_item.last_point),
    .status     (status),
    .busy       (busy),
    .cmd        (cmd)
  );

  pcob_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

>>> verif/tb.sv
// Testbench: random and directed point clusters, checked against an exact box predictor.
`timescale 1ns / 1ps
module tb;
  import pcob_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    point_t pt;
    bit     drain;
  } pend_t;

  localparam int CYCLE_LIMIT = 600000;

  logic    clk = 0;
  logic    rst_n;
  logic    start;
  logic    busy;
  point_t  in_item;
  logic    out_strobe;
  result_t out_item;

  point_cluster_oriented_box_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  pend_t   point_q[$];
  result_t box_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      gap = 0;
  bit      taken = 0;

  coord_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  coord_t west_y, east_y, far_x, near_x;
  bit     in_cluster = 0;

  task automatic report(string what, result_t got, result_t want);
    errors++;
    $display("mismatch %s: got %p want %p", what, got, want);
  endtask

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic coord_t clamp(wide_t v);
    if (v > 128'sd8388607) return 24'sh7fffff;
    if (v < -128'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic coord_t mid(coord_t a, coord_t b);
    wide_t s;
    wide_t h;
    s = wide_t'(a) + wide_t'(b);
    h = floor_div(s, 2);
    return h[23:0];
  endfunction

  task automatic corner_at(input wide_t px, py, qx, qy, d1x, d1y, d2x, d2y, cr,
                           output coord_t ox, oy);
    wide_t num;
    num = (qx - px) * d2y - (qy - py) * d2x;
    ox = clamp(px + floor_div(num * d1x, cr));
    oy = clamp(py + floor_div(num * d1y, cr));
  endtask

  task automatic add_box_result(logic [2:0] kind, coord_t x, coord_t y, coord_t z, bit deg,
                                bit last);
    result_t r;
    r.item_kind = kind; r.out_x = x; r.out_y = y; r.out_z = z;
    r.out_z_bottom = lo_z; r.degenerate = deg; r.last_result = last;
    box_q.push_back(r);
  endtask

  task automatic track_point(point_t p);
    wide_t d1x, d1y, d2x, d2y, cr;
    coord_t cx, cy, ox, oy;
    bit deg;
    if (!in_cluster) begin
      lo_x = p.point_x; hi_x = p.point_x; lo_y = p.point_y; hi_y = p.point_y;
      lo_z = p.point_z; hi_z = p.point_z;
      west_y = p.point_y; east_y = p.point_y; far_x = p.point_x; near_x = p.point_x;
      in_cluster = 1;
    end else begin
      if (p.point_z > hi_z) hi_z = p.point_z;
      if (p.point_z < lo_z) lo_z = p.point_z;
      if (p.point_x > hi_x) begin hi_x = p.point_x; east_y = p.point_y; end
      if (p.point_x < lo_x) begin lo_x = p.point_x; west_y = p.point_y; end
      if (p.point_y > hi_y) begin hi_y = p.point_y; far_x = p.point_x; end
      if (p.point_y < lo_y) begin lo_y = p.point_y; near_x = p.point_x; end
    end
    if (!p.last_point) return;
    in_cluster = 0;
    cx = mid(lo_x, hi_x);
    cy = mid(lo_y, hi_y);
    d1x = wide_t'(far_x) - wide_t'(near_x);
    d1y = wide_t'(hi_y) - wide_t'(lo_y);
    d2x = wide_t'(hi_x) - wide_t'(lo_x);
    d2y = wide_t'(east_y) - wide_t'(west_y);
    cr = d1x * d2y - d1y * d2x;
    deg = (cr == 0);
    add_box_result(KIND_CENTER, cx, cy, mid(lo_z, hi_z), deg, 0);
    if (deg) begin
      add_box_result(KIND_WEST_NEAR, cx, cy, hi_z, 1, 0);
      add_box_result(KIND_WEST_FAR, cx, cy, hi_z, 1, 0);
      add_box_result(KIND_EAST_FAR, cx, cy, hi_z, 1, 0);
      add_box_result(KIND_EAST_NEAR, cx, cy, hi_z, 1, 1);
      return;
    end
    corner_at(lo_x, west_y, near_x, lo_y, d1x, d1y, d2x, d2y, cr, ox, oy);
    add_box_result(KIND_WEST_NEAR, ox, oy, hi_z, 0, 0);
    corner_at(lo_x, west_y, far_x, hi_y, d1x, d1y, d2x, d2y, cr, ox, oy);
    add_box_result(KIND_WEST_FAR, ox, oy, hi_z, 0, 0);
    corner_at(hi_x, east_y, far_x, hi_y, d1x, d1y, d2x, d2y, cr, ox, oy);
    add_box_result(KIND_EAST_FAR, ox, oy, hi_z, 0, 0);
    corner_at(hi_x, east_y, near_x, lo_y, d1x, d1y, d2x, d2y, cr, ox, oy);
    add_box_result(KIND_EAST_NEAR, ox, oy, hi_z, 0, 1);
  endtask

  task automatic add_point(int x, int y, int z, bit last, bit drain = 0);
    pend_t e;
    e.pt.point_x = x[23:0]; e.pt.point_y = y[23:0]; e.pt.point_z = z[23:0];
    e.pt.last_point = last; e.drain = drain;
    point_q.push_back(e);
  endtask

  task automatic add_cluster(int n, bit wide_spread);
    int bx, by, bz, sp;
    bx = $urandom; by = $urandom; bz = $urandom;
    sp = $urandom_range(1, 3000);
    for (int i = 0; i < n; i++) begin
      if (wide_spread) add_point($urandom, $urandom, $urandom, i == n - 1);
      else add_point(bx + $urandom_range(0, 2 * sp) - sp, by + $urandom_range(0, 2 * sp) - sp,
                     bz + $urandom_range(0, 2 * sp) - sp, i == n - 1);
    end
  endtask

  // request accept, predictor and result check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) track_point(in_item);
    if (rst_n && out_strobe) begin
      if (box_q.size() == 0) begin
        report("unexpected result", out_item, out_item);
      end else begin
        result_t want;
        want = box_q.pop_front();
        if (out_item.item_kind !== want.item_kind) report("item_kind", out_item, want);
        if (out_item.out_x !== want.out_x) report("out_x", out_item, want);
        if (out_item.out_y !== want.out_y) report("out_y", out_item, want);
        if (out_item.out_z !== want.out_z) report("out_z", out_item, want);
        if (out_item.out_z_bottom !== want.out_z_bottom) report("out_z_bottom", out_item, want);
        if (out_item.degenerate !== want.degenerate) report("degenerate", out_item, want);
        if (out_item.last_result !== want.last_result) report("last_result", out_item, want);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("point_cluster_oriented_box_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(start && !taken)) begin
      pend_t e;
      logic nxt_start;
      point_t nxt_item;
      nxt_start = 0;
      nxt_item = in_item;
      if (gap > 0) begin
        gap--;
      end else if (point_q.size() > 0 && !(point_q[0].drain && box_q.size() != 0)) begin
        e = point_q.pop_front();
        nxt_item = e.pt;
        nxt_start = 1;
        if (point_q.size() > 20 && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
      end
      start <= nxt_start;
      in_item <= nxt_item;
    end
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_item = '0;
    // single points at the extremes
    add_point(8388607, 8388607, 8388607, 1);
    add_point(-8388608, -8388608, -8388608, 1);
    // cluster spanning the full range, corners saturate
    add_point(-8388608, 0, -8388608, 0);
    add_point(8388607, 100, 8388607, 0);
    add_point(0, 8388607, 5, 0);
    add_point(3, -8388608, -5, 1);
    // collinear points, parallel directions
    add_point(10, 10, 0, 0);
    add_point(20, 20, 1, 0);
    add_point(30, 30, 2, 1);
    // ties on the extremes, first point wins
    add_point(5, 5, 7, 0);
    add_point(5, 9, 7, 0);
    add_point(-2, 5, -1, 0);
    add_point(-2, -3, -1, 0);
    add_point(8, -3, 0, 1, 1);
    // tilted box, odd sums
    add_point(-101, -7, -3, 0);
    add_point(40, -300, -8, 0);
    add_point(250, 55, 2, 0);
    add_point(-20, 400, 9, 1);
    while (point_q.size() < 110) begin
      add_cluster($urandom_range(1, 8), $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) point_q[point_q.size() - 1].drain = 1;
    end
    repeat (11) @(negedge clk);
    rst_n = 1;
    wait (point_q.size() == 0 && !start);
    wait (box_q.size() == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("point_cluster_oriented_box_top regression: pass");
    else $display("point_cluster_oriented_box_top regression: fail");
    $finish;
  end

endmodule

>>> point_cluster_oriented_box_top.f
rtl/pcob_pkg.sv
rtl/pcob_ctrl.sv
rtl/pcob_dp.sv
rtl/point_cluster_oriented_box_top.sv
verif/tb.sv
